// ===== hw/rtl/lfu_cache_replacement_macros.svh =====
// ---------------------------------------------------------------------------
// LFU cache assertion macros
// Shorthand for the concurrent checks of the LFU cache. Each macro expects
// clk and arst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef LFU_CACHE_REPLACEMENT_MACROS_SVH
`define LFU_CACHE_REPLACEMENT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lfu_cache_replacement: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lfu_cache_replacement: next-cycle check failed");

`endif

// ===== hw/rtl/lfu_pkg.sv =====
// ---------------------------------------------------------------------------
// LFU cache package
// Field widths, request codes, fixed values and the sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 5;

	localparam logic [CFG_W-1:0]   CFG_RESET  = 5'd16;
	localparam logic               MODE_GET   = 1'b0;
	localparam logic               MODE_PUT   = 1'b1;
	localparam logic [KEY_W-1:0]   MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [COUNT_W-1:0] COUNT_ONE  = 32'd1;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DONE   = 5'b10000
	} lfu_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfu_req_if.sv =====
// ---------------------------------------------------------------------------
// LFU cache request channel
// Valid/ready channel carrying one get or put request.
// ---------------------------------------------------------------------------
`default_nettype none

interface lfu_req_if import lfu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic signed [KEY_W-1:0] key;
	logic signed [KEY_W-1:0] put_value;

	modport source (output valid, output mode, output key, output put_value, input ready);
	modport sink (input valid, input mode, input key, input put_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfu_rsp_if.sv =====
// ---------------------------------------------------------------------------
// LFU cache response channel
// Valid/ready channel carrying the outcome of one request.
// ---------------------------------------------------------------------------
`default_nettype none

interface lfu_rsp_if import lfu_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    hit;
	logic signed [KEY_W-1:0] read_value;
	logic                    evicted;
	logic signed [KEY_W-1:0] evicted_key;

	modport source (output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink (input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lfu_cache_replacement.sv =====
// ---------------------------------------------------------------------------
// LFU cache with recency tie break
// Key/value store of up to CAPACITY entries that evicts the least frequently
// used entry, breaking ties by the oldest last touch.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake         payload
//   req      in         valid/ready       mode, key, put_value
//   rsp      out        valid/ready       hit, read_value, evicted, evicted_key
//   cfg      in         cfg_we (no wait)  cfg_wdata = capacity_in_use
//
// A request that changes the store runs a second sweep; one that does not
// (a get miss, or a put with capacity zero) goes from the decision straight
// to the response. The two sweeps come from the single read port of the
// entry memory: one sweep finds the hit, the victim and a free slot, a
// second sweep rewrites use counts and ranks. Reset clears the valid bits,
// the occupancy and the sequencer at once; there is no clearing pass. A
// stalled response holds in the output register while a new request is
// taken and worked on; that request then waits at its end.
//
`default_nettype none

`include "lfu_cache_replacement_macros.svh"

module lfu_cache_replacement import lfu_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	lfu_req_if.sink               req,
	lfu_rsp_if.source             rsp,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	// Index width, counter width (holds CAPACITY itself) and compare width.
	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = IW + 1;
	localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

	localparam logic [IW-1:0]   LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CW-1:0]   DEPTH_CW = CW'(CAPACITY);
	localparam logic [CMPW-1:0] DEPTH_CM = CMPW'(CAPACITY);

	// One memory word holds everything about an entry except its valid bit.
	// The rank is 0 for the most recently touched valid entry.
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [KEY_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [IW-1:0]      rank;
	} entry_t;

	localparam int EW = $bits(entry_t);

	// Sequencer and sweep pointer.
	lfu_state_t      state_q;
	logic [CW-1:0]   idx_q;
	logic            vld_s1;
	logic [IW-1:0]   idx_s1;

	// Request being served.
	logic             req_mode_q;
	logic [KEY_W-1:0] req_key_q;
	logic [KEY_W-1:0] req_val_q;

	// Findings of the first sweep.
	logic               found_q;
	logic [IW-1:0]      fidx_q;
	logic [KEY_W-1:0]   fval_q;
	logic [COUNT_W-1:0] fcnt_q;
	logic [IW-1:0]      frank_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic               vic_q;
	logic [IW-1:0]      vidx_q;
	logic [COUNT_W-1:0] vcnt_q;
	logic [IW-1:0]      vrank_q;
	logic [KEY_W-1:0]   vkey_q;

	// Plan for the second sweep.
	logic [IW-1:0] tgt_idx_q;
	entry_t        tgt_word_q;
	logic [IW-1:0] old_rank_q;
	logic          all_q;

	// Response waiting for the output register.
	logic             res_hit_q;
	logic [KEY_W-1:0] res_rv_q;
	logic             res_ev_q;
	logic [KEY_W-1:0] res_ek_q;

	// Architectural state kept in flops.
	logic [CAPACITY-1:0] valid_q;
	logic [CW-1:0]       occ_q;
	logic [CFG_W-1:0]    cap_q;

	// Output register.
	logic             ovld_q;
	logic             out_hit_q;
	logic [KEY_W-1:0] out_rv_q;
	logic             out_ev_q;
	logic [KEY_W-1:0] out_ek_q;

	// Memory port signals.
	logic          mem_rd_en;
	logic [IW-1:0] mem_rd_addr;
	logic [EW-1:0] mem_rd_data;
	logic          mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	logic [EW-1:0] mem_wr_data;
	entry_t        rdw;

	// Decision terms.
	logic [CMPW-1:0]    cap_ext;
	logic [CMPW-1:0]    cap_eff;
	logic [CMPW-1:0]    occ_ext;
	logic               is_put;
	logic               cap_zero;
	logic               do_touch;
	logic               do_evict;
	logic               do_insert;
	logic [COUNT_W-1:0] bumped;
	logic               s1_valid;
	logic               key_match;
	logic               better;
	logic               age_it;
	logic               out_free;
	entry_t             aged_word;
	entry_t             touch_word;
	entry_t             new_word;

	lfu_entry_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (EW),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	assign rdw = entry_t'(mem_rd_data);

	// Both sweeps read one entry a cycle; the data returns in the next cycle as
	// stage 1. Writes in the update sweep go to the stage 1 entry, so the
	// write always trails the read by one address and never collides.
	assign mem_rd_en   = (state_q == ST_SCAN || state_q == ST_UPDATE) && (idx_q < DEPTH_CW);
	assign mem_rd_addr = idx_q[IW-1:0];

	assign s1_valid  = valid_q[idx_s1];
	assign key_match = s1_valid && (rdw.key == req_key_q);
	// Lowest count wins; among equal counts the oldest (largest rank) wins.
	assign better    = s1_valid && (!vic_q || (rdw.count < vcnt_q)
		|| ((rdw.count == vcnt_q) && (rdw.rank > vrank_q)));

	// Touch and evict-then-insert age the valid entries that were younger
	// than a reference rank; an insert into a free slot ages all.
	assign age_it = s1_valid && (all_q || (rdw.rank < old_rank_q));

	always_comb begin
		aged_word      = rdw;
		aged_word.rank = rdw.rank + IW'(1);
	end

	assign mem_wr_en   = (state_q == ST_UPDATE) && vld_s1 && ((idx_s1 == tgt_idx_q) || age_it);
	assign mem_wr_addr = idx_s1;
	assign mem_wr_data = (idx_s1 == tgt_idx_q) ? EW'(tgt_word_q) : EW'(aged_word);

	// Capacity in use, clamped to the number of slots.
	assign cap_ext = CMPW'(cap_q);
	assign cap_eff = (cap_ext > DEPTH_CM) ? DEPTH_CM : cap_ext;
	assign occ_ext = CMPW'(occ_q);

	assign is_put    = (req_mode_q == MODE_PUT);
	assign cap_zero  = (cap_eff == '0);
	assign do_touch  = found_q && (!is_put || !cap_zero);
	assign do_evict  = is_put && !cap_zero && !found_q && (occ_ext >= cap_eff) && vic_q;
	assign do_insert = is_put && !cap_zero && !found_q && !do_evict && free_q;
	assign bumped    = (fcnt_q == COUNT_MAX) ? fcnt_q : (fcnt_q + COUNT_ONE);

	always_comb begin
		touch_word.key   = req_key_q;
		touch_word.value = is_put ? req_val_q : fval_q;
		touch_word.count = bumped;
		touch_word.rank  = '0;
		new_word.key     = req_key_q;
		new_word.value   = req_val_q;
		new_word.count   = COUNT_ONE;
		new_word.rank    = '0;
	end

	assign out_free = !ovld_q || rsp.ready;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
			vic_q   <= 1'b0;
			valid_q <= '0;
			occ_q   <= '0;
			cap_q   <= CFG_RESET;
			ovld_q  <= 1'b0;
		end else begin
			vld_s1 <= mem_rd_en;
			if (mem_rd_en) begin
				idx_q  <= idx_q + CW'(1);
				idx_s1 <= idx_q[IW-1:0];
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// The output register loads when the sequencer finishes and drains
			// when the consumer takes the response.
			ovld_q <= (state_q == ST_DONE && out_free) || (ovld_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						vic_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (vld_s1) begin
						if (key_match && !found_q) begin
							found_q <= 1'b1;
						end
						if (!s1_valid && !free_q) begin
							free_q <= 1'b1;
						end
						if (better) begin
							vic_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					idx_q <= '0;
					if (do_touch || do_evict || do_insert) begin
						state_q <= ST_UPDATE;
					end else begin
						state_q <= ST_DONE;
					end
					if (do_insert) begin
						valid_q[free_idx_q] <= 1'b1;
						occ_q               <= occ_q + CW'(1);
					end
				end
				ST_UPDATE: begin
					if (vld_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			req_mode_q <= req.mode;
			req_key_q  <= req.key;
			req_val_q  <= req.put_value;
		end
		if (state_q == ST_SCAN && vld_s1) begin
			if (key_match && !found_q) begin
				fidx_q  <= idx_s1;
				fval_q  <= rdw.value;
				fcnt_q  <= rdw.count;
				frank_q <= rdw.rank;
			end
			if (!s1_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (better) begin
				vidx_q  <= idx_s1;
				vcnt_q  <= rdw.count;
				vrank_q <= rdw.rank;
				vkey_q  <= rdw.key;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_hit_q <= found_q;
			res_rv_q  <= is_put ? '0 : (found_q ? fval_q : MISS_VALUE);
			res_ev_q  <= do_evict;
			res_ek_q  <= do_evict ? vkey_q : '0;
			if (do_touch) begin
				tgt_idx_q  <= fidx_q;
				tgt_word_q <= touch_word;
				old_rank_q <= frank_q;
				all_q      <= 1'b0;
			end else if (do_evict) begin
				// The victim leaves and the new key takes its slot at rank 0:
				// entries younger than the victim age, older ones keep rank.
				tgt_idx_q  <= vidx_q;
				tgt_word_q <= new_word;
				old_rank_q <= vrank_q;
				all_q      <= 1'b0;
			end else begin
				tgt_idx_q  <= free_idx_q;
				tgt_word_q <= new_word;
				old_rank_q <= '0;
				all_q      <= 1'b1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_hit_q <= res_hit_q;
			out_rv_q  <= res_rv_q;
			out_ev_q  <= res_ev_q;
			out_ek_q  <= res_ek_q;
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = ovld_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.read_value  = out_rv_q;
	assign rsp.evicted     = out_ev_q;
	assign rsp.evicted_key = out_ek_q;

	`LFU_ASSERT_NOW(a_no_rw_collision, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
	`LFU_ASSERT_NOW(a_occ_tracks_valid, state_q != ST_DECIDE, $countones(valid_q) == int'(occ_q))
	`LFU_ASSERT_NEXT(a_accept_starts_scan, req.valid && req.ready, state_q == ST_SCAN)
	`LFU_ASSERT_NOW(a_evict_on_put_miss, state_q == ST_DONE && res_ev_q, req_mode_q == MODE_PUT && !res_hit_q)

endmodule

`default_nettype wire

// ===== hw/rtl/lfu_entry_mem.sv =====
// ---------------------------------------------------------------------------
// LFU cache entry memory
// Simple dual-port synchronous RAM, one write and one registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_entry_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 100,
	parameter int AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
